>>> rtl/mkts_pkg.sv
// ============================================================================
// mkts_pkg: shared types and constants for the masked knn top-k selector
// item structs, widths and the command record passed front to back
// ============================================================================
package mkts_pkg;

    localparam int MAX_NEIGHBORS  = 32;
    localparam int MAX_COLUMNS    = 256;
    localparam int ROW_INDEX_BITS = 16;

    localparam int COL_BITS  = $clog2(MAX_COLUMNS);
    localparam int HEAP_BITS = $clog2(MAX_NEIGHBORS);
    localparam int CNT_BITS  = 6;
    localparam int SUM_BITS  = 42;
    localparam int DIST_BITS = 50;
    localparam int PAIR_BITS = 9;
    localparam int TOT_BITS  = 9;

    localparam logic [1:0] CFG_NEIGHBOR_COUNT = 2'd0;
    localparam logic [1:0] CFG_METRIC_MODE    = 2'd1;
    localparam logic [1:0] CFG_COLUMN_TOTAL   = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] sample_value;
        logic        is_missing;
        logic [15:0] candidate_row;
        logic        row_end;
        logic        query_end;
    } t_in_item;

    typedef struct packed {
        logic [DIST_BITS-1:0] neighbor_distance;
        logic [15:0]          neighbor_row;
        logic [5:0]           found_count;
        logic                 last_result;
    } t_out_item;

    // one finished row (or a bare query end) handed from front to back
    typedef struct packed {
        logic                 offer;
        logic                 query_end;
        logic [SUM_BITS-1:0]  sum;
        logic [PAIR_BITS-1:0] pairs;
        logic [15:0]          row;
    } t_cmd;

endpackage

>>> rtl/mkts_front.sv
// ============================================================================
// mkts_front: element front end
// stores the target row, accumulates masked distances, issues row commands
// ============================================================================
module mkts_front import mkts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    input  logic     i_metric,
    output logic     o_cmd_valid,
    input  logic     i_cmd_full,
    output t_cmd     o_cmd
);

    logic [16:0]          r_target [MAX_COLUMNS];
    logic [COL_BITS-1:0]  r_pos;
    logic [SUM_BITS-1:0]  r_sum;
    logic [PAIR_BITS-1:0] r_pairs;
    // stage 1: registered item plus target read
    logic                 r_s1_valid;
    t_in_item             r_s1;
    logic [16:0]          r_t;
    logic [SUM_BITS-1:0]  n_sum;
    logic [PAIR_BITS-1:0] n_pairs;
    logic signed [16:0]   w_diff;
    logic [16:0]          w_abs;
    logic [33:0]          w_term;
    logic [SUM_BITS:0]    w_add;
    logic                 w_present;
    logic                 w_accept;
    logic                 w_end;

    // stage 1 waits while it holds an item and the command queue is full
    assign o_stall  = r_s1_valid && i_cmd_full;
    assign w_accept = i_valid && !o_stall;

    // target memory write and read, column counter
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!i_data.kind) begin
                r_target[r_pos] <= {i_data.is_missing, i_data.sample_value};
            end
            r_t <= r_target[r_pos];
            r_s1 <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (!o_stall) r_s1_valid <= w_accept;
            if (w_accept) begin
                r_pos <= (i_data.row_end || i_data.query_end) ? '0 : r_pos + 1'b1;
            end
        end
    end

    // a target element written at the same column earlier in this row is
    // read one item later only across rows, so the read-before-write is fine
    assign w_present = r_s1.kind && !r_t[16] && !r_s1.is_missing;
    assign w_diff    = $signed({r_t[15], r_t[15:0]}) -
                       $signed({r_s1.sample_value[15], r_s1.sample_value});
    assign w_abs     = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_term    = i_metric ? 34'(w_abs) : 34'(w_abs * w_abs);
    assign w_add     = {1'b0, r_sum} + (SUM_BITS+1)'(w_term);
    assign w_end     = r_s1.row_end || r_s1.query_end;

    always_comb begin
        n_sum   = r_sum;
        n_pairs = r_pairs;
        if (w_present) begin
            n_sum = w_add[SUM_BITS] ? '1 : w_add[SUM_BITS-1:0];
            if (r_pairs != '1) n_pairs = r_pairs + 1'b1;
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_pairs <= '0;
        end else if (r_s1_valid && !o_stall) begin
            r_sum   <= w_end ? '0 : n_sum;
            r_pairs <= w_end ? '0 : n_pairs;
        end
    end

    assign o_cmd_valid     = r_s1_valid && !i_cmd_full && w_end;
    assign o_cmd.offer     = r_s1.kind && (n_pairs != '0);
    assign o_cmd.query_end = r_s1.query_end;
    assign o_cmd.sum       = n_sum;
    assign o_cmd.pairs     = n_pairs;
    assign o_cmd.row       = r_s1.candidate_row;

endmodule

>>> rtl/mkts_queue.sv
// ============================================================================
// mkts_queue: command queue
// four-entry fifo between the front end and the heap engine
// ============================================================================
module mkts_queue import mkts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    t_cmd       r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    // no overflow and no underflow
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("queue push while full");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid)) else $error("queue pop while empty");

endmodule

>>> rtl/mkts_back.sv
// ============================================================================
// mkts_back: heap engine
// scales each row distance, maintains the max-heap, emits results
// ============================================================================
module mkts_back import mkts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  t_cmd                i_cmd,
    input  logic [CNT_BITS-1:0] i_k,
    input  logic [TOT_BITS-1:0] i_total,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out_item           o_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_OFFER = 4'd3;
    localparam logic [3:0] ST_HEAP  = 4'd4;
    localparam logic [3:0] ST_SIFT  = 4'd5;
    localparam logic [3:0] ST_SREAD = 4'd6;
    localparam logic [3:0] ST_EMIT  = 4'd7;
    localparam logic [3:0] ST_ERD   = 4'd8;
    localparam logic [3:0] ST_AFTER = 4'd9;

    localparam int PROD_BITS = SUM_BITS + TOT_BITS;

    logic [3:0]            r_state;
    t_cmd                  r_cmd;
    logic [PROD_BITS-1:0]  r_num;
    logic [PROD_BITS-1:0]  r_rem;
    logic [5:0]            r_bit;
    logic [PROD_BITS-1:0]  r_quot;
    logic [DIST_BITS-1:0]  r_dist;
    logic [DIST_BITS-1:0]  r_dh [MAX_NEIGHBORS];
    logic [15:0]           r_rh [MAX_NEIGHBORS];
    logic [CNT_BITS:0]     r_fill;
    logic [CNT_BITS:0]     r_kk;
    // sift state
    logic [CNT_BITS:0]     r_at;
    logic [CNT_BITS:0]     r_size;
    logic [CNT_BITS:0]     r_hi;
    logic                  r_build;
    logic                  r_final;
    logic [DIST_BITS-1:0]  r_vd;
    logic [15:0]           r_vr;
    logic [CNT_BITS:0]     r_emit;
    logic                  r_ovalid;
    t_out_item             r_out;
    logic [PROD_BITS:0]    w_trial;
    logic [CNT_BITS+1:0]   w_l;
    logic [CNT_BITS+1:0]   w_r;
    logic [CNT_BITS:0]     w_c;
    logic [CNT_BITS:0]     w_kc;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // clamp k
    assign w_kc = (i_k == '0) ? (CNT_BITS+1)'(1) :
                  ((CNT_BITS+1)'(i_k) > (CNT_BITS+1)'(MAX_NEIGHBORS)) ?
                  (CNT_BITS+1)'(MAX_NEIGHBORS) : (CNT_BITS+1)'(i_k);

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    // restoring divider trial
    assign w_trial = {r_rem, r_num[PROD_BITS-1]} - (PROD_BITS+1)'(r_cmd.pairs);

    // sift children
    assign w_l = {r_at, 1'b1};
    assign w_r = w_l + 1'b1;
    assign w_c = ((w_r < (CNT_BITS+2)'(r_size)) &&
                  (r_dh[w_r[HEAP_BITS-1:0]] > r_dh[w_l[HEAP_BITS-1:0]])) ?
                 w_r[CNT_BITS:0] : w_l[CNT_BITS:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_final  <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && r_state != ST_EMIT) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_kk  <= w_kc;
                        r_state <= i_cmd.offer ? ST_MUL : ST_AFTER;
                    end
                end
                ST_MUL: begin
                    r_num  <= PROD_BITS'(r_cmd.sum * i_total);
                    r_rem  <= '0;
                    r_quot <= '0;
                    r_bit  <= 6'(PROD_BITS);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // one quotient bit per cycle
                    if (!w_trial[PROD_BITS]) begin
                        r_rem  <= w_trial[PROD_BITS-1:0];
                        r_quot <= {r_quot[PROD_BITS-2:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[PROD_BITS-2:0], r_num[PROD_BITS-1]};
                        r_quot <= {r_quot[PROD_BITS-2:0], 1'b0};
                    end
                    r_num <= {r_num[PROD_BITS-2:0], 1'b0};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 6'd1) r_state <= ST_OFFER;
                end
                ST_OFFER: begin
                    r_dist <= (r_quot[PROD_BITS-1:DIST_BITS] != '0) ? '1 :
                              r_quot[DIST_BITS-1:0];
                    r_state <= ST_HEAP;
                end
                ST_HEAP: begin
                    if (r_fill < r_kk) begin
                        r_dh[r_fill[HEAP_BITS-1:0]] <= r_dist;
                        r_rh[r_fill[HEAP_BITS-1:0]] <= r_cmd.row;
                        r_fill <= r_fill + 1'b1;
                        if (r_fill + 1'b1 == r_kk && r_kk > 1) begin
                            r_size  <= r_kk;
                            r_build <= 1'b1;
                            r_hi    <= (r_kk - 2'd2) >> 1;
                            r_state <= ST_SREAD;
                        end else begin
                            r_state <= ST_AFTER;
                        end
                    end else if (r_dist < r_dh[0]) begin
                        r_dh[0] <= r_dist;
                        r_rh[0] <= r_cmd.row;
                        r_vd <= r_dist;
                        r_vr <= r_cmd.row;
                        r_at <= '0;
                        r_size  <= r_fill;
                        r_build <= 1'b0;
                        r_state <= ST_SIFT;
                    end else begin
                        r_state <= ST_AFTER;
                    end
                end
                ST_SREAD: begin
                    // start sift of node r_hi during build
                    r_at <= r_hi;
                    r_vd <= r_dh[r_hi[HEAP_BITS-1:0]];
                    r_vr <= r_rh[r_hi[HEAP_BITS-1:0]];
                    r_state <= ST_SIFT;
                end
                ST_SIFT: begin
                    if (w_l < (CNT_BITS+2)'(r_size) &&
                        r_dh[w_c[HEAP_BITS-1:0]] > r_vd) begin
                        r_dh[r_at[HEAP_BITS-1:0]] <= r_dh[w_c[HEAP_BITS-1:0]];
                        r_rh[r_at[HEAP_BITS-1:0]] <= r_rh[w_c[HEAP_BITS-1:0]];
                        r_dh[w_c[HEAP_BITS-1:0]]  <= r_vd;
                        r_rh[w_c[HEAP_BITS-1:0]]  <= r_vr;
                        r_at <= w_c;
                    end else if (r_build && r_hi != '0) begin
                        r_hi <= r_hi - 1'b1;
                        r_state <= ST_SREAD;
                    end else begin
                        r_state <= ST_AFTER;
                    end
                end
                ST_AFTER: begin
                    if (r_cmd.query_end && r_fill > 1 && !r_final) begin
                        // build over all held rows, then come back here
                        r_size  <= r_fill;
                        r_build <= 1'b1;
                        r_hi    <= (r_fill - 2'd2) >> 1;
                        r_final <= 1'b1;
                        r_state <= ST_SREAD;
                    end else if (r_cmd.query_end) begin
                        r_final <= 1'b0;
                        r_emit  <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        if (r_fill == '0) begin
                            r_out <= '{neighbor_distance: '0, neighbor_row: '0,
                                       found_count: '0, last_result: 1'b1};
                            r_state <= ST_IDLE;
                        end else begin
                            r_out.neighbor_distance <= r_dh[r_emit[HEAP_BITS-1:0]];
                            r_out.neighbor_row      <= r_rh[r_emit[HEAP_BITS-1:0]];
                            r_out.found_count       <= CNT_BITS'(r_fill);
                            r_out.last_result       <= (r_emit + 1'b1 == r_fill);
                            r_emit <= r_emit + 1'b1;
                            if (r_emit + 1'b1 == r_fill) begin
                                r_fill  <= '0;
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ST_ERD kept as a reserved code for the read slot of emission
    a_no_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_ERD) else $error("reserved state reached");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (CNT_BITS+1)'(MAX_NEIGHBORS)) else $error("heap overfilled");
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> $stable(r_out)) else $error("held result changed");
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> r_ovalid) else $error("held result dropped");

endmodule

>>> rtl/masked_knn_top_k_select.sv
// ============================================================================
// masked_knn_top_k_select: k nearest rows with missing-value masking
// front end accumulates per-element distances, back end keeps a max-heap
// ============================================================================
// Elements are taken at up to one per cycle; the input stalls while the
// front stage holds an element and the four-entry command queue is full.
// A candidate row end with a present pair goes through the engine's pop, multiply,
// bit-serial scaling divide, saturate, heap update and finish, plus a sift
// from the root on a root replacement; a target row end only passes pop and
// finish. When the k-th row arrives, and again at every query end with more
// than one row held, the heap is built bottom-up, each internal node taking
// a read step plus its sift steps. Results then leave at one per cycle while
// the receiver does not stall. The queue lets short rows overlap heap work.
module masked_knn_top_k_select import mkts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    logic [CNT_BITS-1:0] r_k;
    logic                r_metric;
    logic [TOT_BITS-1:0] r_total;
    logic                w_cmd_valid;
    logic                w_full;
    logic                w_qvalid;
    logic                w_pop;
    t_cmd                w_cmd;
    t_cmd                w_qcmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= CNT_BITS'(5);
            r_metric <= 1'b0;
            r_total  <= TOT_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NEIGHBOR_COUNT: r_k      <= i_cfg_data[CNT_BITS-1:0];
                CFG_METRIC_MODE:    r_metric <= i_cfg_data[0];
                CFG_COLUMN_TOTAL:   r_total  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mkts_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .i_metric(r_metric), .o_cmd_valid(w_cmd_valid),
        .i_cmd_full(w_full), .o_cmd(w_cmd)
    );

    mkts_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_cmd_valid), .i_data(w_cmd),
        .o_full(w_full), .o_valid(w_qvalid), .i_pop(w_pop), .o_data(w_qcmd)
    );

    mkts_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_qvalid), .o_cmd_pop(w_pop),
        .i_cmd(w_qcmd), .i_k(r_k), .i_total(r_total),
        .o_valid, .i_stall, .o_data
    );

endmodule
